[hw/rtl/mdpf_pkg.sv]
// mdpf_pkg: shared widths, codes and types of the min difference pair finder
// used by the channel interfaces, the sorter cells and the top level
`default_nettype none

package mdpf_pkg;

  localparam int MAX_VALUES_DEF = 256;
  localparam int VAL_W          = 32;
  localparam int POS_W          = 9;
  localparam int STAT_W         = 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_MANY = 2'd1,
    STAT_TOO_FEW  = 2'd2
  } status_t;

  // per-cycle command shared by every cell of the chain
  typedef struct packed {
    logic ins;
    logic drn;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/mdpf_in_if.sv]
// mdpf_in_if: input channel, one value beat with its last flag
// depends on mdpf_pkg for the value width
`default_nettype none

interface mdpf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mdpf_pkg::VAL_W-1:0]  value;
  logic                               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/mdpf_out_if.sv]
// mdpf_out_if: result channel, positions, difference and status per beat
// depends on mdpf_pkg for the field widths
`default_nettype none

interface mdpf_out_if;
  logic                          valid;
  logic                          ready;
  logic [mdpf_pkg::POS_W-1:0]    first_pos;
  logic [mdpf_pkg::POS_W-1:0]    second_pos;
  logic [mdpf_pkg::VAL_W-1:0]    min_difference;
  logic [mdpf_pkg::STAT_W-1:0]   status;

  modport source (output valid, output first_pos, output second_pos,
                  output min_difference, output status, input ready);
  modport sink   (input valid, input first_pos, input second_pos,
                  input min_difference, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/mdpf_cell.sv]
// mdpf_cell: one cell of the insertion sort chain, holds a value and its arrival index
// depends on mdpf_pkg for the value width and the chain command type
`default_nettype none

module mdpf_cell #(
  parameter int IDX_W = 8
) (
  input  wire                               clk,
  input  wire mdpf_pkg::cell_ctl_t          ctl,
  input  wire                               occ,
  input  wire signed [mdpf_pkg::VAL_W-1:0]  new_val,
  input  wire        [IDX_W-1:0]            new_pos,
  input  wire                               prev_gt,
  input  wire signed [mdpf_pkg::VAL_W-1:0]  prev_val,
  input  wire        [IDX_W-1:0]            prev_pos,
  input  wire signed [mdpf_pkg::VAL_W-1:0]  next_val,
  input  wire        [IDX_W-1:0]            next_pos,
  output logic signed [mdpf_pkg::VAL_W-1:0] val_q,
  output logic        [IDX_W-1:0]           pos_q,
  output logic                              gt
);

  logic signed [mdpf_pkg::VAL_W-1:0] val_r;
  logic        [IDX_W-1:0]           pos_r;

  // strict compare keeps equal values in arrival order
  always_comb begin
    gt = occ && (val_r > new_val);
  end

  always_ff @(posedge clk) begin
    if (ctl.drn) begin
      val_r <= next_val;
      pos_r <= next_pos;
    end else if (ctl.ins) begin
      if (prev_gt) begin
        val_r <= prev_val;
        pos_r <= prev_pos;
      end else if (gt || !occ) begin
        val_r <= new_val;
        pos_r <= new_pos;
      end
    end
  end

  assign val_q = val_r;
  assign pos_q = pos_r;

endmodule

`default_nettype wire

[hw/rtl/mdpf_scan.sv]
// mdpf_scan: walks the sorted values leaving cell 0 and keeps the closest adjacent pair
// depends on mdpf_pkg for the value width
`default_nettype none

module mdpf_scan #(
  parameter int IDX_W = 8
) (
  input  wire                               clk,
  input  wire                               step,
  input  wire                               first,
  input  wire                               second,
  input  wire signed [mdpf_pkg::VAL_W-1:0]  cur_val,
  input  wire        [IDX_W-1:0]            cur_pos,
  output logic       [mdpf_pkg::VAL_W-1:0]  best_diff,
  output logic       [IDX_W-1:0]            lo_pos,
  output logic       [IDX_W-1:0]            hi_pos
);

  logic signed [mdpf_pkg::VAL_W-1:0] prev_val_r;
  logic        [IDX_W-1:0]           prev_pos_r;
  logic        [mdpf_pkg::VAL_W-1:0] best_diff_r;
  logic        [IDX_W-1:0]           lo_pos_r;
  logic        [IDX_W-1:0]           hi_pos_r;
  logic        [mdpf_pkg::VAL_W-1:0] diff;
  logic                              take;

  // sorted order: difference is exact as unsigned, first strict minimum wins ties
  always_comb begin
    diff = mdpf_pkg::VAL_W'(cur_val - prev_val_r);
    take = !first && (second || (diff < best_diff_r));
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prev_val_r <= cur_val;
      prev_pos_r <= cur_pos;
      if (take) begin
        best_diff_r <= diff;
        lo_pos_r    <= prev_pos_r;
        hi_pos_r    <= cur_pos;
      end
    end
  end

  assign best_diff = best_diff_r;
  assign lo_pos    = lo_pos_r;
  assign hi_pos    = hi_pos_r;

endmodule

`default_nettype wire

[hw/rtl/min_difference_pair_finder_top.sv]
// min_difference_pair_finder_top: sorter cell chain, pair scan, control and result register
// depends on mdpf_pkg, mdpf_in_if, mdpf_out_if, mdpf_cell and mdpf_scan
//
//   channel | dir | beat
//   in_ch   | in  | value (signed 32), last
//   out_ch  | out | first_pos, second_pos, min_difference, status
//
// each accepted value beat, up to MAX_VALUES per set, is inserted in sorted place by the cell chain
// after the last beat of an ok set the chain drains through cell 0 in sorted order
// into the pair scan, and the result is loaded once the drain is done and out_ch is free
// error sets (too many or fewer than two values) skip the drain and go straight to emit
// synchronous active-low reset empties the set; cell contents need no clearing
// input is stalled only while draining or while a result waits to be loaded into out_ch
`default_nettype none

module min_difference_pair_finder_top #(
  parameter int MAX_VALUES = mdpf_pkg::MAX_VALUES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  mdpf_in_if.sink    in_ch,
  mdpf_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_VALUES);
  localparam int CNT_W = $clog2(MAX_VALUES + 1);

  mdpf_pkg::state_t    state_r, state_nxt;
  mdpf_pkg::status_t   stat_r, stat_nxt;
  mdpf_pkg::cell_ctl_t ctl;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_after;
  logic [CNT_W-1:0] drn_r;
  logic             ovf_r;
  logic             ovf_now;
  logic             stored;
  logic             in_acc;
  logic             drain_done;
  logic             emit_go;

  logic signed [mdpf_pkg::VAL_W-1:0] cell_val [MAX_VALUES];
  logic        [IDX_W-1:0]           cell_pos [MAX_VALUES];
  logic                              cell_gt  [MAX_VALUES];

  logic [mdpf_pkg::VAL_W-1:0] best_diff;
  logic [IDX_W-1:0]           lo_pos;
  logic [IDX_W-1:0]           hi_pos;

  logic                         out_valid_r;
  logic [mdpf_pkg::POS_W-1:0]   first_pos_r;
  logic [mdpf_pkg::POS_W-1:0]   second_pos_r;
  logic [mdpf_pkg::VAL_W-1:0]   min_diff_r;
  logic [mdpf_pkg::STAT_W-1:0]  status_r;

  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    stored     = cnt_r < CNT_W'(MAX_VALUES);
    ovf_now    = ovf_r || !stored;
    cnt_after  = cnt_r + CNT_W'(stored);
    drain_done = drn_r == (cnt_r - CNT_W'(1));
    if (ovf_now) begin
      stat_nxt = mdpf_pkg::STAT_TOO_MANY;
    end else if (cnt_after < CNT_W'(2)) begin
      stat_nxt = mdpf_pkg::STAT_TOO_FEW;
    end else begin
      stat_nxt = mdpf_pkg::STAT_OK;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdpf_pkg::ST_LOAD: begin
        if (in_acc && in_ch.last) begin
          state_nxt = (stat_nxt == mdpf_pkg::STAT_OK) ? mdpf_pkg::ST_DRAIN
                                                      : mdpf_pkg::ST_EMIT;
        end
      end
      mdpf_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = mdpf_pkg::ST_EMIT;
        end
      end
      mdpf_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = mdpf_pkg::ST_LOAD;
        end
      end
      default: state_nxt = mdpf_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ctl         = '0;
    emit_go     = 1'b0;
    unique case (state_r)
      mdpf_pkg::ST_LOAD: begin
        in_ch.ready = 1'b1;
        ctl.ins     = in_ch.valid && stored;
      end
      mdpf_pkg::ST_DRAIN: begin
        ctl.drn = 1'b1;
      end
      mdpf_pkg::ST_EMIT: begin
        emit_go = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdpf_pkg::ST_LOAD;
      stat_r  <= mdpf_pkg::STAT_OK;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      drn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        cnt_r <= cnt_after;
        ovf_r <= ovf_now;
        if (in_ch.last) begin
          stat_r <= stat_nxt;
          drn_r  <= '0;
        end
      end
      if (ctl.drn) begin
        drn_r <= drn_r + CNT_W'(1);
      end
      if (emit_go) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  // sorter chain
  for (genvar g = 0; g < MAX_VALUES; g++) begin : g_cell
    logic                              occ;
    logic                              p_gt;
    logic signed [mdpf_pkg::VAL_W-1:0] p_val;
    logic        [IDX_W-1:0]           p_pos;
    logic signed [mdpf_pkg::VAL_W-1:0] n_val;
    logic        [IDX_W-1:0]           n_pos;

    assign occ = CNT_W'(g) < cnt_r;

    if (g == 0) begin : g_head
      assign p_gt  = 1'b0;
      assign p_val = '0;
      assign p_pos = '0;
    end else begin : g_body
      assign p_gt  = cell_gt[g-1];
      assign p_val = cell_val[g-1];
      assign p_pos = cell_pos[g-1];
    end

    if (g == MAX_VALUES - 1) begin : g_tail
      assign n_val = '0;
      assign n_pos = '0;
    end else begin : g_mid
      assign n_val = cell_val[g+1];
      assign n_pos = cell_pos[g+1];
    end

    mdpf_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ),
      .new_val  (in_ch.value),
      .new_pos  (cnt_r[IDX_W-1:0]),
      .prev_gt  (p_gt),
      .prev_val (p_val),
      .prev_pos (p_pos),
      .next_val (n_val),
      .next_pos (n_pos),
      .val_q    (cell_val[g]),
      .pos_q    (cell_pos[g]),
      .gt       (cell_gt[g])
    );
  end

  mdpf_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk       (clk),
    .step      (ctl.drn),
    .first     (drn_r == '0),
    .second    (drn_r == CNT_W'(1)),
    .cur_val   (cell_val[0]),
    .cur_pos   (cell_pos[0]),
    .best_diff (best_diff),
    .lo_pos    (lo_pos),
    .hi_pos    (hi_pos)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      status_r <= stat_r;
      if (stat_r == mdpf_pkg::STAT_OK) begin
        first_pos_r  <= mdpf_pkg::POS_W'({1'b0, lo_pos} + (IDX_W + 1)'(1));
        second_pos_r <= mdpf_pkg::POS_W'({1'b0, hi_pos} + (IDX_W + 1)'(1));
        min_diff_r   <= best_diff;
      end else begin
        first_pos_r  <= '0;
        second_pos_r <= '0;
        min_diff_r   <= '0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.first_pos      = first_pos_r;
  assign out_ch.second_pos     = second_pos_r;
  assign out_ch.min_difference = min_diff_r;
  assign out_ch.status         = status_r;

endmodule

`default_nettype wire

[tb/sv/mdpf_pair_checker.sv]
`timescale 1ns / 100ps
// mdpf_pair_checker: watches both channels of the min difference pair finder,
// predicts the closest pair of each set and compares every result beat
// depends on mdpf_pkg, mdpf_in_if and mdpf_out_if

module mdpf_pair_checker #(
  parameter int MAX_VALUES = mdpf_pkg::MAX_VALUES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  mdpf_in_if    in_ch,
  mdpf_out_if   out_ch,
  output int    mismatch_count,
  output int    pairs_pending
);
  import mdpf_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] second_pos;
    logic [VAL_W-1:0] min_difference;
    status_t          status;
  } pair_result_t;

  logic signed [VAL_W-1:0] set_vals [MAX_VALUES];
  int                      set_count;
  logic                    set_over;
  pair_result_t            expected_pairs [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // brute force over all pairs of the stored set
  function automatic pair_result_t closest_pair();
    pair_result_t            r;
    logic [VAL_W-1:0]        d;
    logic [VAL_W-1:0]        best_d;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] best_lo;
    logic signed [VAL_W-1:0] best_hi;
    int                      fi;
    int                      si;
    int                      from;
    bit                      have;
    r = '0;
    if (set_over) begin
      r.status = STAT_TOO_MANY;
    end else if (set_count < 2) begin
      r.status = STAT_TOO_FEW;
    end else begin
      have    = 1'b0;
      best_d  = '0;
      best_lo = '0;
      best_hi = '0;
      for (int i = 0; i < set_count; i++) begin
        for (int j = i + 1; j < set_count; j++) begin
          lo = (set_vals[i] < set_vals[j]) ? set_vals[i] : set_vals[j];
          hi = (set_vals[i] < set_vals[j]) ? set_vals[j] : set_vals[i];
          d  = hi - lo;
          if (!have || d < best_d || (d == best_d && lo < best_lo)) begin
            have    = 1'b1;
            best_d  = d;
            best_lo = lo;
            best_hi = hi;
          end
        end
      end
      fi = 0;
      for (int i = 0; i < set_count; i++) begin
        if (set_vals[i] == best_lo) begin
          fi = i;
          break;
        end
      end
      // equal values: second position is the next occurrence
      from = (best_lo == best_hi) ? fi + 1 : 0;
      si = 0;
      for (int i = from; i < set_count; i++) begin
        if (set_vals[i] == best_hi) begin
          si = i;
          break;
        end
      end
      r.first_pos      = POS_W'(fi + 1);
      r.second_pos     = POS_W'(si + 1);
      r.min_difference = best_d;
      r.status         = STAT_OK;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pair_result_t e;
    if (!rst_n) begin
      set_count = 0;
      set_over  = 1'b0;
      expected_pairs.delete();
      pairs_pending <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (set_count < MAX_VALUES) begin
          set_vals[set_count] = in_ch.value;
          set_count++;
        end else begin
          set_over = 1'b1;
        end
        if (in_ch.last) begin
          expected_pairs.push_back(closest_pair());
          set_count = 0;
          set_over  = 1'b0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("result beat with no set closed");
        end else begin
          e = expected_pairs.pop_front();
          if (out_ch.first_pos !== e.first_pos)
            report_mismatch($sformatf("first_pos got %0d expected %0d",
                                      out_ch.first_pos, e.first_pos));
          if (out_ch.second_pos !== e.second_pos)
            report_mismatch($sformatf("second_pos got %0d expected %0d",
                                      out_ch.second_pos, e.second_pos));
          if (out_ch.min_difference !== e.min_difference)
            report_mismatch($sformatf("min_difference got %0h expected %0h",
                                      out_ch.min_difference, e.min_difference));
          if (out_ch.status !== e.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_ch.status, e.status));
        end
      end
      pairs_pending <= expected_pairs.size();
    end
  end

endmodule

[tb/sv/min_difference_pair_finder_top_tb.sv]
`timescale 1ns / 100ps
// min_difference_pair_finder_top_tb: clock, reset, value beats and result back-pressure
// for the min difference pair finder; checking is done by mdpf_pair_checker
// depends on mdpf_pkg, mdpf_in_if, mdpf_out_if and mdpf_pair_checker

module min_difference_pair_finder_top_tb;
  import mdpf_pkg::*;

  typedef enum int {
    FILL_WIDE,
    FILL_NARROW,
    FILL_CLUSTER,
    FILL_EDGE
  } fill_t;

  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_WAIT = MAX_VALUES_DEF + 50;
  localparam int DIR_N      = 22;

  localparam logic signed [VAL_W-1:0] DIR_VALS [DIR_N] = '{
    32'sh8000_0000, 32'sh7fff_ffff,
    32'sd42,
    32'sd5, 32'sd3, 32'sd5, 32'sd3,
    32'sd10, 32'sd0, 32'sd20, 32'sd30,
    32'sd7, 32'sd7, 32'sd7,
    -32'sd5, 32'sd6, -32'sd3, 32'sd4,
    -32'sd1, 32'sh7fff_ffff,
    -32'sd1, 32'sd0
  };
  localparam bit DIR_LAST [DIR_N] = '{
    0, 1,
    1,
    0, 0, 0, 1,
    0, 0, 0, 1,
    0, 0, 1,
    0, 0, 0, 1,
    0, 1,
    0, 1
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    tb_valid  = 1'b0;
  logic signed [VAL_W-1:0] tb_value  = '0;
  logic                    tb_last   = 1'b0;
  logic                    snk_ready = 1'b0;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int items_sent   = 0;
  int set_no       = 0;
  bit hold_req     = 1'b0;
  bit hold_seen    = 1'b0;
  int hold_left    = 0;

  int mismatch_count;
  int pairs_pending;

  always #4 clk = ~clk;

  mdpf_in_if  in_ch ();
  mdpf_out_if out_ch ();

  assign in_ch.valid  = tb_valid;
  assign in_ch.value  = tb_value;
  assign in_ch.last   = tb_last;
  assign out_ch.ready = snk_ready;

  min_difference_pair_finder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mdpf_pair_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pairs_pending  (pairs_pending)
  );

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      snk_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_req;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      snk_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      snk_ready <= 1'b0;
    end else begin
      snk_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // valid stays high from one beat to the next unless an idle cycle falls between
  task automatic send_beat(input logic signed [VAL_W-1:0] v, input logic l);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      tb_valid <= 1'b0;
      @(posedge clk);
    end
    tb_valid <= 1'b1;
    tb_value <= v;
    tb_last  <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_results_drained();
    tb_valid <= 1'b0;
    do @(negedge clk); while (pairs_pending != 0);
    @(posedge clk);
  endtask

  task automatic send_random_sets(input int item_goal);
    int                      set_len;
    int                      pick;
    fill_t                   fill;
    logic signed [VAL_W-1:0] base;
    logic signed [VAL_W-1:0] v;
    while (items_sent < item_goal) begin
      set_no++;
      pick = $urandom_range(0, 99);
      if (set_no == 12)
        set_len = MAX_VALUES_DEF;
      else if (set_no == 30)
        set_len = MAX_VALUES_DEF + 1 + $urandom_range(0, 3);
      else if (pick < 8)
        set_len = 1;
      else if (pick < 85)
        set_len = $urandom_range(2, 10);
      else
        set_len = $urandom_range(11, 40);
      fill = fill_t'($urandom_range(0, 3));
      base = $urandom;
      for (int k = 0; k < set_len; k++) begin
        case (fill)
          FILL_WIDE:    v = $urandom;
          FILL_NARROW:  v = int'($urandom_range(0, 16)) - 8;
          FILL_CLUSTER: v = base + int'($urandom_range(0, 63));
          default: begin
            case ($urandom_range(0, 4))
              0:       v = 32'sh8000_0000;
              1:       v = 32'sh7fff_ffff;
              2:       v = '0;
              3:       v = -1;
              default: v = $urandom;
            endcase
          end
        endcase
        send_beat(v, k == set_len - 1);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 8;
    snk_idle_pct <= 88;
    for (int i = 0; i < DIR_N; i++)
      send_beat(DIR_VALS[i], DIR_LAST[i]);
    send_random_sets(530);
    wait_results_drained();

    src_idle_pct = 88;
    snk_idle_pct <= 8;
    send_random_sets(1040);
    wait_results_drained();

    // no idling; the result side holds off so the block backs up into its input
    src_idle_pct = 0;
    snk_idle_pct <= 0;
    hold_req <= ~hold_req;
    send_random_sets(1550);
    wait_results_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mdpf_pkg.sv
hw/rtl/mdpf_in_if.sv
hw/rtl/mdpf_out_if.sv
hw/rtl/mdpf_cell.sv
hw/rtl/mdpf_scan.sv
hw/rtl/min_difference_pair_finder_top.sv
tb/sv/mdpf_pair_checker.sv
tb/sv/min_difference_pair_finder_top_tb.sv
